// ===== rtl/arp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP responder package
// Shared constants, the reply descriptor type and byte helpers.
// ----------------------------------------------------------------------------
package arp_pkg;

  // Byte positions inside an ARP-over-Ethernet frame.
  localparam int unsigned REPLY_LEN = 42;
  localparam logic [5:0]  LAST_POS  = 6'(REPLY_LEN - 1);
  localparam logic [5:0]  ETYPE_HI_POS = 6'd12;
  localparam logic [5:0]  ETYPE_LO_POS = 6'd13;
  localparam logic [5:0]  HTYPE_HI_POS = 6'd14;
  localparam logic [5:0]  HTYPE_LO_POS = 6'd15;
  localparam logic [5:0]  PTYPE_HI_POS = 6'd16;
  localparam logic [5:0]  PTYPE_LO_POS = 6'd17;
  localparam logic [5:0]  OPER_HI_POS  = 6'd20;
  localparam logic [5:0]  OPER_LO_POS  = 6'd21;
  localparam logic [5:0]  SHA_POS      = 6'd22;
  localparam logic [5:0]  SPA_POS      = 6'd28;
  localparam logic [5:0]  THA_POS      = 6'd32;
  localparam logic [5:0]  TPA_POS      = 6'd38;
  localparam logic [5:0]  SRC_MAC_POS  = 6'd6;
  localparam logic [5:0]  FIXED_POS    = 6'd12;

  // Header constants.
  localparam logic [7:0] ETYPE_ARP_HI = 8'h08;
  localparam logic [7:0] ETYPE_ARP_LO = 8'h06;
  localparam logic [7:0] HTYPE_ETH_HI = 8'h00;
  localparam logic [7:0] HTYPE_ETH_LO = 8'h01;
  localparam logic [7:0] PTYPE_IP_HI  = 8'h08;
  localparam logic [7:0] PTYPE_IP_LO  = 8'h00;
  localparam logic [7:0] OPER_REQ_HI  = 8'h00;
  localparam logic [7:0] OPER_REQ_LO  = 8'h01;

  // Configuration register indexes.
  localparam logic [1:0] CFG_OWN_MAC = 2'd0;
  localparam logic [1:0] CFG_OWN_IP  = 2'd1;

  // Fixed middle part of the reply: EtherType through opcode.
  localparam logic [7:0] REPLY_FIXED [10] = '{
    8'h08, 8'h06, 8'h00, 8'h01, 8'h08, 8'h00, 8'h06, 8'h04, 8'h00, 8'h02
  };

  // What the parser hands to the reply generator.
  typedef struct packed {
    logic [47:0] mac;
    logic [31:0] ip;
  } arp_reply_t;

  // Byte k of a MAC address, first transmitted byte at k = 0.
  function automatic logic [7:0] mac_byte(logic [47:0] v, logic [2:0] k);
    logic [47:0] s;
    s = v >> {3'd5 - k, 3'b000};
    return s[7:0];
  endfunction

  // Byte k of an IPv4 address, first transmitted byte at k = 0.
  function automatic logic [7:0] ip_byte(logic [31:0] v, logic [1:0] k);
    logic [31:0] s;
    s = v >> {2'd3 - k, 3'b000};
    return s[7:0];
  endfunction

endpackage

// ===== rtl/arp_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP reply queue
// Small register FIFO of reply descriptors between parser and generator.
// ----------------------------------------------------------------------------
module arp_fifo import arp_pkg::*; #(
  parameter int unsigned DEPTH = 2  // at least 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  arp_reply_t push_data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output arp_reply_t head_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

  arp_reply_t         slot_q [DEPTH];
  logic [PW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]      count_q, count_d;
  logic               do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Descriptor storage carries no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/arp_rx_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP request parser
// Walks the received frame, checks the request fields and captures the
// sender addresses; queues a reply descriptor on a matching request.
// ----------------------------------------------------------------------------
module arp_rx_parser import arp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_end_i,
  input  logic [31:0] own_ip_i,
  input  logic        queue_full_i,
  output logic        push_o,
  output arp_reply_t  push_data_o
);

  logic [5:0]  pos_q, pos_d;
  logic        chk_q, chk_d;
  logic [47:0] rmac_q, rmac_d;
  logic [31:0] rip_q, rip_d;
  logic        accept, in_arp, bad;

  // Only the byte that would queue a reply can wait on a full queue.
  assign in_ready_o = !((pos_q == LAST_POS) && queue_full_i);
  assign accept     = in_valid_i && in_ready_o;
  assign in_arp     = (pos_q <= LAST_POS);

  // Per-byte header and target address check.
  always_comb begin
    bad = 1'b0;
    unique case (pos_q)
      ETYPE_HI_POS: bad = (in_byte_i != ETYPE_ARP_HI);
      ETYPE_LO_POS: bad = (in_byte_i != ETYPE_ARP_LO);
      HTYPE_HI_POS: bad = (in_byte_i != HTYPE_ETH_HI);
      HTYPE_LO_POS: bad = (in_byte_i != HTYPE_ETH_LO);
      PTYPE_HI_POS: bad = (in_byte_i != PTYPE_IP_HI);
      PTYPE_LO_POS: bad = (in_byte_i != PTYPE_IP_LO);
      OPER_HI_POS:  bad = (in_byte_i != OPER_REQ_HI);
      OPER_LO_POS:  bad = (in_byte_i != OPER_REQ_LO);
      default:      bad = 1'b0;
    endcase
    if (in_arp && (pos_q >= TPA_POS)) begin
      bad = bad || (in_byte_i != ip_byte(own_ip_i, 2'(pos_q - TPA_POS)));
    end
  end

  // A reply goes out when the last ARP byte completes a clean request.
  assign push_o           = accept && (pos_q == LAST_POS) && chk_q && !bad;
  assign push_data_o.mac  = rmac_q;
  assign push_data_o.ip   = rip_q;

  // Position, check flag and address capture.
  always_comb begin
    pos_d  = pos_q;
    chk_d  = chk_q;
    rmac_d = rmac_q;
    rip_d  = rip_q;
    if (accept) begin
      if (in_arp) begin
        chk_d = chk_q && !bad;
        if ((pos_q >= SHA_POS) && (pos_q < SPA_POS)) begin
          rmac_d = {rmac_q[39:0], in_byte_i};
        end
        if ((pos_q >= SPA_POS) && (pos_q < THA_POS)) begin
          rip_d = {rip_q[23:0], in_byte_i};
        end
        pos_d = pos_q + 6'd1;
      end
      if (in_end_i) begin
        pos_d = '0;
        chk_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      chk_q  <= 1'b1;
      rmac_q <= '0;
      rip_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      chk_q  <= chk_d;
      rmac_q <= rmac_d;
      rip_q  <= rip_d;
    end
  end

endmodule

// ===== rtl/arp_tx_gen.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP reply generator
// Serializes the 42-byte reply for the descriptor at the queue head.
// ----------------------------------------------------------------------------
module arp_tx_gen import arp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        queue_empty_i,
  input  arp_reply_t  head_i,
  output logic        pop_o,
  input  logic [47:0] own_mac_i,
  input  logic [31:0] own_ip_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o
);

  logic [5:0] cnt_q, cnt_d;
  logic       take;

  assign out_valid_o = !queue_empty_i;
  assign take        = out_valid_o && out_ready_i;
  assign out_last_o  = (cnt_q == LAST_POS);
  assign pop_o       = take && out_last_o;

  // Reply byte at the current position.
  always_comb begin
    priority if (cnt_q < SRC_MAC_POS) begin
      out_byte_o = mac_byte(head_i.mac, 3'(cnt_q));
    end else if (cnt_q < FIXED_POS) begin
      out_byte_o = mac_byte(own_mac_i, 3'(cnt_q - SRC_MAC_POS));
    end else if (cnt_q < SHA_POS) begin
      out_byte_o = REPLY_FIXED[4'(cnt_q - FIXED_POS)];
    end else if (cnt_q < SPA_POS) begin
      out_byte_o = mac_byte(own_mac_i, 3'(cnt_q - SHA_POS));
    end else if (cnt_q < THA_POS) begin
      out_byte_o = ip_byte(own_ip_i, 2'(cnt_q - SPA_POS));
    end else if (cnt_q < TPA_POS) begin
      out_byte_o = mac_byte(head_i.mac, 3'(cnt_q - THA_POS));
    end else begin
      out_byte_o = ip_byte(head_i.ip, 2'(cnt_q - TPA_POS));
    end
  end

  // Byte counter wraps after the last reply byte.
  always_comb begin
    cnt_d = cnt_q;
    if (take) begin
      cnt_d = out_last_o ? '0 : cnt_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== rtl/arp_request_responder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP request responder
// Answers ARP requests for our IPv4 address with a 42-byte reply frame.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload                          Accepted when
//  s_axis    in   frame byte, tlast = frame end    s_axis_tvalid_i & s_axis_tready_o
//  m_axis    out  reply byte, tlast = reply last   m_axis_tvalid_o & m_axis_tready_i
//  cfg       in   index 0 own MAC, 1 own IPv4      cfg_valid_i & cfg_ready_o
//
//  Received bytes are taken one per cycle unless the receive side stalls.
//  A reply is 42 bytes on m_axis, one byte per cycle while m_axis_tready_i is high.
//  Replies wait in a QUEUE_DEPTH-entry queue; the receive side stalls only on
//  byte 41 of a frame while that queue is full. Output stalls hold the byte.
//  Reset is asynchronous; it clears positions, pointers and registers, but not the
//  queue's descriptor storage, and sets the check flag.
// ----------------------------------------------------------------------------
module arp_request_responder_unit import arp_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2  // at least 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] frame_byte
  input  logic        s_axis_tlast_i,   // frame_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] reply_byte
  output logic        m_axis_tlast_o,   // reply_last
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i
);

  logic [47:0] own_mac_q;
  logic [31:0] own_ip_q;
  logic        push, pop, full, empty;
  arp_reply_t  push_data, head;

  // Configuration registers; writes to other indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_mac_q <= '0;
      own_ip_q  <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_OWN_MAC) begin
        own_mac_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_OWN_IP) begin
        own_ip_q <= cfg_data_i[31:0];
      end
    end
  end

  // Front: frame parser.
  arp_rx_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_byte_i    (s_axis_tdata_i),
    .in_end_i     (s_axis_tlast_i),
    .own_ip_i     (own_ip_q),
    .queue_full_i (full),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  // Reply descriptor queue.
  arp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  // Back: reply serializer.
  arp_tx_gen u_gen (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .queue_empty_i (empty),
    .head_i        (head),
    .pop_o         (pop),
    .own_mac_i     (own_mac_q),
    .own_ip_i      (own_ip_q),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_byte_o    (m_axis_tdata_o),
    .out_last_o    (m_axis_tlast_o)
  );

endmodule
